// ===== rtl/ffha_pkg.sv =====
// Shared types and constants for the first-fit heap allocator.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package ffha_pkg;

    localparam int DEF_HEAP_WORDS  = 16384;
    localparam int DEF_CHUNK_BYTES = 4096;

    // byte addresses carry two spare bits so that sums and differences of
    // 32-bit tag sizes never wrap; a negative address reads as out of store
    localparam int ADDR_W = 34;
    localparam int WORD_W = 32;
    localparam int NEED_W = 17;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OOM  = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [2:0] {
        AS_FOUR, AS_BP_M4, AS_BP_M8, AS_PV_M4, AS_TA
    } addr_sel_t;

    typedef enum logic [1:0] {
        DS_SZ, DS_NEED1, DS_ONE
    } data_sel_t;

    typedef enum logic [2:0] {
        BS_HOLD, BS_ADDR, BS_FIRST, BS_ADV, BS_TOP, BS_PV
    } bp_sel_t;

    typedef enum logic [2:0] {
        TS_HOLD, TS_BP_D_M8, TS_BP_D_M4, TS_PV_D_M8, TS_BP_S_M8, TS_BP_S_M4, TS_BP_N_M4
    } ta_sel_t;

    typedef enum logic [2:0] {
        SS_HOLD, SS_REM, SS_SIZE, SS_SUM, SS_GROW
    } sz_sel_t;

    typedef struct packed {
        logic      clr_step;
        logic      in_load;
        logic      mem_rd;
        logic      mem_wr;
        addr_sel_t asel;
        data_sel_t dsel;
        bp_sel_t   bp_sel;
        logic      pv_load;
        ta_sel_t   ta_sel;
        sz_sel_t   sz_sel;
        logic      top_load;
        logic      res_load;
        logic      res_use_bp;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic cmd_free;
        logic free_ok;
        logic req_zero;
        logic d_alloc;
        logic d_size_zero;
        logic d_fits;
        logic bp_at_top;
        logic grow_fits;
        logic sz_zero;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/ffha_datapath.sv =====
// Datapath: heap word store, clearing counter, block pointers and tag arithmetic.
// Driven by ffha_controller through dp_cmd_t; depends on ffha_pkg.
`default_nettype none

module ffha_datapath
    import ffha_pkg::*;
#(
    parameter int HEAP_WORDS  = DEF_HEAP_WORDS,
    parameter int CHUNK_BYTES = DEF_CHUNK_BYTES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dp_cmd_t     ctl,
    output dp_stat_t         stat,
    input  wire logic        cmd,
    input  wire logic [15:0] request_bytes,
    input  wire logic [15:0] block_addr,
    output logic [15:0]      result_addr
);

    localparam int IW = $clog2(HEAP_WORDS);
    localparam int TW = $clog2(HEAP_WORDS * 4 + 1);
    localparam logic [ADDR_W-1:0] HEAP_BYTES = ADDR_W'(HEAP_WORDS) << 2;
    localparam int GROW0 = ((CHUNK_BYTES / 4 + 1) / 2) * 8;
    localparam bit FIT0 = (16 + GROW0) <= (HEAP_WORDS * 4);
    localparam logic [TW-1:0] TOP_RESET = FIT0 ? TW'(16 + GROW0) : TW'(16);
    localparam logic [IW:0] FOOT_IDX0 = (IW+1)'((8 + GROW0) / 4);
    localparam logic [IW:0] EPI_IDX0  = (IW+1)'((12 + GROW0) / 4);
    localparam logic [WORD_W-1:0] HDR0 = FIT0 ? WORD_W'(GROW0) : WORD_W'(1);
    localparam logic [NEED_W-1:0] GROW0_N = NEED_W'(GROW0);
    localparam logic [IW:0] LAST_IDX = (IW+1)'(HEAP_WORDS - 1);

    logic [WORD_W-1:0] mem [HEAP_WORDS];
    logic [WORD_W-1:0] mem_q_reg;
    logic              q_in_reg;

    logic [IW:0]        clr_idx_reg;
    logic [TW-1:0]      top_reg;
    logic               cmd_reg;
    logic [NEED_W-1:0]  need_reg;
    logic [15:0]        req_reg;
    logic [15:0]        addr_in_reg;
    logic [ADDR_W-1:0]  bp_reg;
    logic [ADDR_W-1:0]  pv_reg;
    logic [ADDR_W-1:0]  ta_reg;
    logic [WORD_W-1:0]  sz_reg;
    logic [15:0]        result_addr_reg;

    logic [WORD_W-1:0] d_word;
    logic [WORD_W-1:0] d_size;
    logic [ADDR_W-1:0] d_size_x;
    logic [ADDR_W-1:0] sz_x;
    logic [ADDR_W-1:0] acc_addr;
    logic              acc_in;
    logic [IW-1:0]     acc_idx;
    logic [WORD_W-1:0] wdata;
    logic [WORD_W-1:0] init_word;
    logic [NEED_W-1:0] need_new;
    logic [NEED_W-1:0] grow_amt;

    assign d_word   = q_in_reg ? mem_q_reg : '0;
    assign d_size   = {d_word[WORD_W-1:3], 3'b000};
    assign d_size_x = ADDR_W'(d_size);
    assign sz_x     = ADDR_W'(sz_reg);
    assign need_new = (NEED_W'(request_bytes) + NEED_W'(15)) & ~NEED_W'(7);
    assign grow_amt = (need_reg > GROW0_N) ? need_reg : GROW0_N;

    always_comb
    begin
        case (ctl.asel)
            AS_FOUR:  acc_addr = ADDR_W'(4);
            AS_BP_M4: acc_addr = bp_reg - ADDR_W'(4);
            AS_BP_M8: acc_addr = bp_reg - ADDR_W'(8);
            AS_PV_M4: acc_addr = pv_reg - ADDR_W'(4);
            AS_TA:    acc_addr = ta_reg;
            default:  acc_addr = ta_reg;
        endcase
        case (ctl.dsel)
            DS_SZ:    wdata = sz_reg;
            DS_NEED1: wdata = WORD_W'(need_reg) | WORD_W'(1);
            DS_ONE:   wdata = WORD_W'(1);
            default:  wdata = sz_reg;
        endcase
    end

    // out-of-store and negative addresses both land at or above HEAP_BYTES
    assign acc_in  = acc_addr < HEAP_BYTES;
    assign acc_idx = acc_addr[IW+1:2];

    always_comb
    begin
        if (clr_idx_reg == (IW+1)'(1) || clr_idx_reg == (IW+1)'(2))
            init_word = WORD_W'(9);
        else if (clr_idx_reg == (IW+1)'(3))
            init_word = HDR0;
        else if (FIT0 && clr_idx_reg == FOOT_IDX0)
            init_word = WORD_W'(GROW0);
        else if (FIT0 && clr_idx_reg == EPI_IDX0)
            init_word = WORD_W'(1);
        else
            init_word = '0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clr_step)
            mem[clr_idx_reg[IW-1:0]] <= init_word;
        else if (ctl.mem_wr && acc_in)
            mem[acc_idx] <= wdata;
        if (ctl.mem_rd)
        begin
            mem_q_reg <= mem[acc_idx];
            q_in_reg  <= acc_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            top_reg     <= TOP_RESET;
        end
        else
        begin
            if (ctl.clr_step)
                clr_idx_reg <= clr_idx_reg + (IW+1)'(1);
            if (ctl.top_load)
                top_reg <= TW'(bp_reg + sz_x);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.in_load)
        begin
            cmd_reg     <= cmd;
            req_reg     <= request_bytes;
            need_reg    <= need_new;
            addr_in_reg <= block_addr;
        end
        case (ctl.bp_sel)
            BS_HOLD:  bp_reg <= bp_reg;
            BS_ADDR:  bp_reg <= ADDR_W'(addr_in_reg);
            BS_FIRST: bp_reg <= ADDR_W'(8) + d_size_x;
            BS_ADV:   bp_reg <= bp_reg + d_size_x;
            BS_TOP:   bp_reg <= ADDR_W'(top_reg);
            BS_PV:    bp_reg <= pv_reg;
            default:  bp_reg <= bp_reg;
        endcase
        if (ctl.pv_load)
            pv_reg <= bp_reg - d_size_x;
        case (ctl.ta_sel)
            TS_HOLD:    ta_reg <= ta_reg;
            TS_BP_D_M8: ta_reg <= bp_reg + d_size_x - ADDR_W'(8);
            TS_BP_D_M4: ta_reg <= bp_reg + d_size_x - ADDR_W'(4);
            TS_PV_D_M8: ta_reg <= pv_reg + d_size_x - ADDR_W'(8);
            TS_BP_S_M8: ta_reg <= bp_reg + sz_x - ADDR_W'(8);
            TS_BP_S_M4: ta_reg <= bp_reg + sz_x - ADDR_W'(4);
            TS_BP_N_M4: ta_reg <= bp_reg + ADDR_W'(need_reg) - ADDR_W'(4);
            default:    ta_reg <= ta_reg;
        endcase
        case (ctl.sz_sel)
            SS_HOLD: sz_reg <= sz_reg;
            SS_REM:  sz_reg <= d_size - WORD_W'(need_reg);
            SS_SIZE: sz_reg <= d_size;
            SS_SUM:  sz_reg <= d_size + sz_reg;
            SS_GROW: sz_reg <= WORD_W'(grow_amt);
            default: sz_reg <= sz_reg;
        endcase
        if (ctl.res_load)
            result_addr_reg <= ctl.res_use_bp ? bp_reg[15:0] : 16'd0;
    end

    always_comb
    begin
        stat.clr_done    = clr_idx_reg == LAST_IDX;
        stat.cmd_free    = cmd_reg == CMD_FREE;
        stat.free_ok     = addr_in_reg[2:0] == 3'd0 && addr_in_reg >= 16'd16 &&
                           ADDR_W'(addr_in_reg) < ADDR_W'(top_reg);
        stat.req_zero    = req_reg == 16'd0;
        stat.d_alloc     = d_word[0];
        stat.d_size_zero = d_size == '0;
        stat.d_fits      = d_size >= WORD_W'(need_reg);
        stat.bp_at_top   = bp_reg >= ADDR_W'(top_reg);
        stat.grow_fits   = (ADDR_W'(top_reg) + ADDR_W'(grow_amt)) <= HEAP_BYTES;
        stat.sz_zero     = sz_reg == '0;
    end

    assign result_addr = result_addr_reg;

endmodule

`default_nettype wire

// ===== rtl/ffha_controller.sv =====
// Controller: sequences store reads and writes for clear, search, grow, merge and carve.
// Drives ffha_datapath through dp_cmd_t; depends on ffha_pkg.
`default_nettype none

module ffha_controller
    import ffha_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    output logic          res_valid,
    input  wire logic     res_stall,
    output logic [1:0]    status,
    output dp_cmd_t       ctl,
    input  wire dp_stat_t stat
);

    typedef enum logic [5:0] {
        S_INIT, S_IDLE, S_DISP,
        S_SR0, S_SR1, S_SR2,
        S_GR0, S_GR1, S_GR2, S_GR3,
        S_FR0, S_FR1, S_FR2, S_FR3, S_FR4, S_FR5,
        S_MG0, S_MG1, S_MG2, S_MG3, S_MG4, S_MG5, S_MG6, S_MG7,
        S_MG8, S_MG9, S_MG10, S_MG11, S_MG12, S_MG13, S_MG14, S_MG15,
        S_MEND,
        S_CV0, S_CV1, S_CV2, S_CV3, S_CV4, S_CV5, S_CV6, S_CV7,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic       res_valid_reg;
    logic [1:0] status_reg;
    logic [1:0] pend_status_reg, pend_status_next;
    logic       pend_bp_reg, pend_bp_next;

    assign req_stall = state_reg != S_IDLE;
    assign res_valid = res_valid_reg;
    assign status    = status_reg;

    always_comb
    begin
        ctl              = '0;
        state_next       = state_reg;
        pend_status_next = pend_status_reg;
        pend_bp_next     = pend_bp_reg;
        case (state_reg)
            S_INIT:
            begin
                ctl.clr_step = 1'b1;
                if (stat.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.in_load = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                if (stat.cmd_free)
                begin
                    if (stat.free_ok)
                    begin
                        ctl.bp_sel = BS_ADDR;
                        state_next = S_FR0;
                    end
                    else
                    begin
                        pend_status_next = ST_OK;
                        pend_bp_next     = 1'b0;
                        state_next       = S_DONE;
                    end
                end
                else if (stat.req_zero)
                begin
                    pend_status_next = ST_ZERO;
                    pend_bp_next     = 1'b0;
                    state_next       = S_DONE;
                end
                else
                begin
                    ctl.mem_rd = 1'b1;
                    ctl.asel   = AS_FOUR;
                    state_next = S_SR0;
                end
            end
            // first-fit walk, one header per read
            S_SR0:
            begin
                ctl.bp_sel = BS_FIRST;
                state_next = S_SR1;
            end
            S_SR1:
            begin
                if (stat.bp_at_top)
                    state_next = S_GR0;
                else
                begin
                    ctl.mem_rd = 1'b1;
                    ctl.asel   = AS_BP_M4;
                    state_next = S_SR2;
                end
            end
            S_SR2:
            begin
                if (stat.d_size_zero)
                    state_next = S_GR0;
                else if (!stat.d_alloc && stat.d_fits)
                    state_next = S_CV0;
                else
                begin
                    ctl.bp_sel = BS_ADV;
                    state_next = S_SR1;
                end
            end
            S_GR0:
            begin
                if (!stat.grow_fits)
                begin
                    pend_status_next = ST_OOM;
                    pend_bp_next     = 1'b0;
                    state_next       = S_DONE;
                end
                else
                begin
                    ctl.sz_sel = SS_GROW;
                    ctl.bp_sel = BS_TOP;
                    state_next = S_GR1;
                end
            end
            S_GR1:
            begin
                ctl.mem_wr = 1'b1;
                ctl.asel   = AS_BP_M4;
                ctl.dsel   = DS_SZ;
                ctl.ta_sel = TS_BP_S_M8;
                state_next = S_GR2;
            end
            S_GR2:
            begin
                ctl.mem_wr = 1'b1;
                ctl.asel   = AS_TA;
                ctl.dsel   = DS_SZ;
                ctl.ta_sel = TS_BP_S_M4;
                state_next = S_GR3;
            end
            S_GR3:
            begin
                // new epilogue
                ctl.mem_wr   = 1'b1;
                ctl.asel     = AS_TA;
                ctl.dsel     = DS_ONE;
                ctl.top_load = 1'b1;
                state_next   = S_MG0;
            end
            S_FR0:
            begin
                ctl.mem_rd = 1'b1;
                ctl.asel   = AS_BP_M4;
                state_next = S_FR1;
            end
            S_FR1:
            begin
                ctl.sz_sel = SS_SIZE;
                state_next = S_FR2;
            end
            S_FR2:
            begin
                ctl.mem_wr = 1'b1;
                ctl.asel   = AS_BP_M4;
                ctl.dsel   = DS_SZ;
                state_next = S_FR3;
            end
            S_FR3:
            begin
                ctl.mem_rd = 1'b1;
                ctl.asel   = AS_BP_M4;
                state_next = S_FR4;
            end
            S_FR4:
            begin
                ctl.ta_sel = TS_BP_D_M8;
                state_next = S_FR5;
            end
            S_FR5:
            begin
                ctl.mem_wr = 1'b1;
                ctl.asel   = AS_TA;
                ctl.dsel   = DS_SZ;
                state_next = S_MG0;
            end
            // coalesce: next neighbour first, then the previous one
            S_MG0:
            begin
                ctl.mem_rd = 1'b1;
                ctl.asel   = AS_BP_M4;
                state_next = S_MG1;
            end
            S_MG1:
            begin
                ctl.ta_sel = TS_BP_D_M4;
                ctl.mem_rd = 1'b1;
                ctl.asel   = AS_BP_M8;
                state_next = S_MG2;
            end
            S_MG2:
            begin
                ctl.pv_load = 1'b1;
                ctl.mem_rd  = 1'b1;
                ctl.asel    = AS_TA;
                state_next  = S_MG3;
            end
            S_MG3:
            begin
                if (!stat.d_alloc)
                begin
                    ctl.sz_sel = SS_SIZE;
                    ctl.mem_rd = 1'b1;
                    ctl.asel   = AS_BP_M4;
                    state_next = S_MG4;
                end
                else
                    state_next = S_MG9;
            end
            S_MG4:
            begin
                ctl.sz_sel = SS_SUM;
                state_next = S_MG5;
            end
            S_MG5:
            begin
                ctl.mem_wr = 1'b1;
                ctl.asel   = AS_BP_M4;
                ctl.dsel   = DS_SZ;
                state_next = S_MG6;
            end
            S_MG6:
            begin
                ctl.mem_rd = 1'b1;
                ctl.asel   = AS_BP_M4;
                state_next = S_MG7;
            end
            S_MG7:
            begin
                ctl.ta_sel = TS_BP_D_M8;
                state_next = S_MG8;
            end
            S_MG8:
            begin
                ctl.mem_wr = 1'b1;
                ctl.asel   = AS_TA;
                ctl.dsel   = DS_SZ;
                state_next = S_MG9;
            end
            S_MG9:
            begin
                ctl.mem_rd = 1'b1;
                ctl.asel   = AS_PV_M4;
                state_next = S_MG10;
            end
            S_MG10:
            begin
                ctl.ta_sel = TS_PV_D_M8;
                state_next = S_MG11;
            end
            S_MG11:
            begin
                ctl.mem_rd = 1'b1;
                ctl.asel   = AS_TA;
                state_next = S_MG12;
            end
            S_MG12:
            begin
                if (!stat.d_alloc)
                begin
                    ctl.sz_sel = SS_SIZE;
                    ctl.mem_rd = 1'b1;
                    ctl.asel   = AS_BP_M4;
                    state_next = S_MG13;
                end
                else
                    state_next = S_MEND;
            end
            S_MG13:
            begin
                ctl.ta_sel = TS_BP_D_M8;
                ctl.sz_sel = SS_SUM;
                state_next = S_MG14;
            end
            S_MG14:
            begin
                ctl.mem_wr = 1'b1;
                ctl.asel   = AS_TA;
                ctl.dsel   = DS_SZ;
                state_next = S_MG15;
            end
            S_MG15:
            begin
                ctl.mem_wr = 1'b1;
                ctl.asel   = AS_PV_M4;
                ctl.dsel   = DS_SZ;
                ctl.bp_sel = BS_PV;
                state_next = S_MEND;
            end
            S_MEND:
            begin
                if (stat.cmd_free)
                begin
                    pend_status_next = ST_OK;
                    pend_bp_next     = 1'b0;
                    state_next       = S_DONE;
                end
                else
                    state_next = S_CV0;
            end
            // place the request and split off any remainder
            S_CV0:
            begin
                ctl.mem_rd = 1'b1;
                ctl.asel   = AS_BP_M4;
                state_next = S_CV1;
            end
            S_CV1:
            begin
                ctl.sz_sel = SS_REM;
                ctl.ta_sel = TS_BP_D_M8;
                state_next = S_CV2;
            end
            S_CV2:
            begin
                ctl.mem_wr = !stat.sz_zero;
                ctl.asel   = AS_TA;
                ctl.dsel   = DS_SZ;
                state_next = S_CV3;
            end
            S_CV3:
            begin
                ctl.mem_wr = 1'b1;
                ctl.asel   = AS_BP_M4;
                ctl.dsel   = DS_NEED1;
                state_next = S_CV4;
            end
            S_CV4:
            begin
                ctl.mem_rd = 1'b1;
                ctl.asel   = AS_BP_M4;
                state_next = S_CV5;
            end
            S_CV5:
            begin
                ctl.ta_sel = TS_BP_D_M8;
                state_next = S_CV6;
            end
            S_CV6:
            begin
                ctl.mem_wr = 1'b1;
                ctl.asel   = AS_TA;
                ctl.dsel   = DS_NEED1;
                ctl.ta_sel = TS_BP_N_M4;
                if (stat.sz_zero)
                begin
                    pend_status_next = ST_OK;
                    pend_bp_next     = 1'b1;
                    state_next       = S_DONE;
                end
                else
                    state_next = S_CV7;
            end
            S_CV7:
            begin
                ctl.mem_wr       = 1'b1;
                ctl.asel         = AS_TA;
                ctl.dsel         = DS_SZ;
                pend_status_next = ST_OK;
                pend_bp_next     = 1'b1;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!res_valid_reg || !res_stall)
                begin
                    ctl.res_load   = 1'b1;
                    ctl.res_use_bp = pend_bp_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            res_valid_reg   <= 1'b0;
            status_reg      <= ST_OK;
            pend_status_reg <= ST_OK;
            pend_bp_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pend_status_reg <= pend_status_next;
            pend_bp_reg     <= pend_bp_next;
            if (ctl.res_load)
            begin
                res_valid_reg <= 1'b1;
                status_reg    <= pend_status_reg;
            end
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    a_no_rd_wr_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.mem_rd && ctl.mem_wr))
        else $error("store read and write issued together");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> state_reg == S_DISP)
        else $error("accepted request not dispatched");

    a_load_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.res_load |-> (!res_valid_reg || !res_stall))
        else $error("result overwritten while stalled");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside completion");

endmodule

`default_nettype wire

// ===== rtl/first_fit_heap_allocator.sv =====
// First-fit heap allocator with boundary tags over an internal word store.
//
// Request channel (req_valid / req_stall): cmd 0 allocates request_bytes,
// cmd 1 frees the payload at block_addr. A request is taken when req_valid
// is high and req_stall low; the block takes one request at a time.
// Result channel (res_valid / res_stall): one result per request, held in an
// output register until taken, so the next request may be accepted while it
// waits.
// Each request is sequenced over the single store port, one read or write per cycle:
// a zero-size allocate or an ignored free does not touch the store, a free
// rewrites its tags and merges with free neighbours, and an allocate reads
// every block header that the first-fit walk visits, grows the heap when no
// block fits, then carves. The next request can be taken in the cycle after
// the result is loaded. After reset the store is swept, one word a cycle, to
// lay down prologue, first free chunk and epilogue; req_stall stays high
// during the sweep. A stalled result stays put, and the block finishes its
// current request and then waits until the output register empties.
// Depends on ffha_pkg, ffha_controller, ffha_datapath.
`default_nettype none

module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_WORDS  = DEF_HEAP_WORDS,
    parameter int CHUNK_BYTES = DEF_CHUNK_BYTES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic        cmd,
    input  wire logic [15:0] request_bytes,
    input  wire logic [15:0] block_addr,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [15:0]      result_addr,
    output logic [1:0]       status
);

    dp_cmd_t  ctl;
    dp_stat_t stat;

    ffha_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .ctl       (ctl),
        .stat      (stat)
    );

    ffha_datapath #(
        .HEAP_WORDS  (HEAP_WORDS),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .cmd           (cmd),
        .request_bytes (request_bytes),
        .block_addr    (block_addr),
        .result_addr   (result_addr)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for first_fit_heap_allocator: directed table, then random
// allocate/free traffic checked against a boundary-tag heap predictor.
// Depends on ffha_pkg and the allocator RTL only.
`timescale 1ns / 100ps

module tb;
    import ffha_pkg::*;

    localparam int HW = DEF_HEAP_WORDS;
    localparam int CB = DEF_CHUNK_BYTES;
    localparam longint unsigned HEAP_BYTES = longint'(HW) * 4;
    localparam int N_RANDOM = 1900;
    localparam int IDLE_PCT = 19;
    localparam int STALL_LIMIT = 400000;

    typedef struct packed {
        logic [15:0] addr;
        logic [1:0]  st;
    } alloc_res_t;

    typedef struct {
        logic        op;
        logic [15:0] nbytes;
        logic [15:0] baddr;
        bit          take_live;
        bit          fixed;
        alloc_res_t  res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic        cmd;
    logic [15:0] request_bytes;
    logic [15:0] block_addr;
    logic        res_valid;
    logic        res_stall;
    logic [15:0] result_addr;
    logic [1:0]  status;

    logic [31:0]     heap_mem [HW];
    longint unsigned heap_end;
    alloc_res_t      pending_q[$];
    int              live_q[$];
    int              errs;
    int              quiet_cycles;
    bit              calm;
    bit              stim_done;

    first_fit_heap_allocator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .cmd           (cmd),
        .request_bytes (request_bytes),
        .block_addr    (block_addr),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .result_addr   (result_addr),
        .status        (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------- heap predictor ----------------
    function automatic logic [31:0] peek(longint unsigned a);
        longint unsigned i;
        i = a >> 2;
        return (i < HW) ? heap_mem[i] : 32'd0;
    endfunction

    function automatic void poke(longint unsigned a, logic [31:0] v);
        longint unsigned i;
        i = a >> 2;
        if (i < HW)
            heap_mem[i] = v;
    endfunction

    function automatic logic [31:0] tag_sz(longint unsigned a);
        return peek(a) & 32'hFFFF_FFF8;
    endfunction

    function automatic logic tag_used(longint unsigned a);
        logic [31:0] v;
        v = peek(a);
        return v[0];
    endfunction

    function automatic longint unsigned footer_of(longint unsigned bp);
        return bp + longint'(tag_sz(bp - 4)) - 8;
    endfunction

    function automatic longint unsigned grow_amount(longint unsigned b);
        return ((b / 4 + 1) / 2) * 8;
    endfunction

    function automatic longint unsigned coalesce(longint unsigned bp);
        longint unsigned nx;
        longint unsigned pv;
        logic [31:0]     s;
        nx = bp + longint'(tag_sz(bp - 4));
        pv = bp - longint'(tag_sz(bp - 8));
        if (!tag_used(nx - 4))
        begin
            s = tag_sz(bp - 4) + tag_sz(nx - 4);
            poke(bp - 4, s);
            poke(footer_of(bp), s);
        end
        if (!tag_used(footer_of(pv)))
        begin
            s = tag_sz(bp - 4) + tag_sz(footer_of(pv));
            poke(footer_of(bp), s);
            poke(pv - 4, s);
            return pv;
        end
        return bp;
    endfunction

    function automatic bit first_free_block(logic [31:0] need, output longint unsigned where);
        longint unsigned bp;
        logic [31:0]     s;
        where = 0;
        bp = 8 + longint'(tag_sz(4));
        while (bp < heap_end)
        begin
            s = tag_sz(bp - 4);
            if (s == 0)
                break;
            if (!tag_used(bp - 4) && s >= need)
            begin
                where = bp;
                return 1'b1;
            end
            bp += longint'(s);
        end
        return 1'b0;
    endfunction

    function automatic void split_block(longint unsigned bp, logic [31:0] need);
        logic [31:0] rem;
        rem = tag_sz(bp - 4) - need;
        if (rem != 0)
        begin
            poke(footer_of(bp), rem);
            poke(bp - 4, need | 32'd1);
            poke(footer_of(bp), need | 32'd1);
            poke(bp + longint'(need) - 4, rem);
        end
        else
        begin
            poke(bp - 4, need | 32'd1);
            poke(footer_of(bp), need | 32'd1);
        end
    endfunction

    function automatic bit raise_top(longint unsigned b, output longint unsigned where);
        longint unsigned s;
        longint unsigned bp;
        where = 0;
        s = grow_amount(b);
        bp = heap_end;
        if (bp + s > HEAP_BYTES)
            return 1'b0;
        poke(bp - 4, s[31:0]);
        poke(bp + s - 8, s[31:0]);
        poke(bp + s - 4, 32'd1);
        heap_end = bp + s;
        where = coalesce(bp);
        return 1'b1;
    endfunction

    function automatic void reset_heap();
        longint unsigned s;
        s = grow_amount(CB);
        foreach (heap_mem[i])
            heap_mem[i] = 32'd0;
        poke(4, 32'd9);
        poke(8, 32'd9);
        poke(12, 32'd1);
        heap_end = 16;
        if (16 + s <= HEAP_BYTES)
        begin
            poke(12, s[31:0]);
            poke(16 + s - 8, s[31:0]);
            poke(16 + s - 4, 32'd1);
            heap_end = 16 + s;
        end
    endfunction

    function automatic alloc_res_t heap_request(logic op, logic [15:0] nb, logic [15:0] ba);
        alloc_res_t      r;
        longint unsigned bp;
        longint unsigned a;
        logic [31:0]     need;
        logic [31:0]     s;
        r.addr = 16'd0;
        r.st = ST_OK;
        a = ba;
        if (op == CMD_FREE)
        begin
            if (ba[2:0] == 3'd0 && a >= 16 && a < heap_end)
            begin
                s = tag_sz(a - 4);
                poke(a - 4, s);
                poke(footer_of(a), s);
                void'(coalesce(a));
            end
            return r;
        end
        if (nb == 16'd0)
        begin
            r.st = ST_ZERO;
            return r;
        end
        need = (32'(nb) + 32'd15) & 32'hFFFF_FFF8;
        if (!first_free_block(need, bp))
        begin
            if (!raise_top((need > CB) ? need : CB, bp))
            begin
                r.st = ST_OOM;
                return r;
            end
        end
        split_block(bp, need);
        r.addr = bp[15:0];
        return r;
    endfunction

    function automatic bit gap_now();
        return !calm && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // ---------------- request side ----------------
    task automatic send_request(logic op, logic [15:0] nb, logic [15:0] ba, bit fixed,
                                alloc_res_t fixed_res);
        alloc_res_t pr;
        while (gap_now())
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        cmd <= op;
        request_bytes <= nb;
        block_addr <= ba;
        do
            @(posedge clk);
        while (req_stall);
        pr = heap_request(op, nb, ba);
        if (op == CMD_ALLOC && pr.st == ST_OK)
            live_q.push_back(int'(pr.addr));
        pending_q.push_back(fixed ? fixed_res : pr);
    endtask

    function automatic logic [15:0] take_live(bit newest);
        int k;
        logic [15:0] a;
        if (live_q.size() == 0)
            return 16'd3;
        k = newest ? live_q.size() - 1 : int'($urandom_range(live_q.size() - 1));
        a = 16'(live_q[k]);
        live_q.delete(k);
        return a;
    endfunction

    function automatic logic [15:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 2)
            return 16'd0;
        if (r < 70)
            return 16'($urandom_range(256, 1));
        if (r < 90)
            return 16'($urandom_range(4096, 257));
        if (r < 97)
            return 16'($urandom_range(20000, 4097));
        return 16'($urandom);
    endfunction

    stim_row_t rows[$];

    initial
    begin
        stim_row_t  w;
        alloc_res_t none;
        logic [15:0] ba;
        int          r;
        none = '0;
        req_valid = 1'b0;
        cmd = CMD_ALLOC;
        request_bytes = 16'd0;
        block_addr = 16'd0;
        stim_done = 1'b0;
        calm = 1'b0;
        errs = 0;
        rst_n = 1'b0;
        reset_heap();

        // op, bytes, addr, free newest live, typed, typed result
        rows = '{
            '{CMD_ALLOC, 16'd0,     16'd0,     0, 1, '{16'd0,  ST_ZERO}},
            '{CMD_ALLOC, 16'hFFFF,  16'd0,     0, 1, '{16'd0,  ST_OOM}},
            '{CMD_ALLOC, 16'd1,     16'd0,     0, 1, '{16'd16, ST_OK}},
            '{CMD_FREE,  16'd0,     16'd16,    0, 1, '{16'd0,  ST_OK}},
            '{CMD_FREE,  16'd0,     16'd3,     0, 1, '{16'd0,  ST_OK}},
            '{CMD_FREE,  16'd0,     16'd8,     0, 1, '{16'd0,  ST_OK}},
            '{CMD_FREE,  16'd0,     16'd0,     0, 1, '{16'd0,  ST_OK}},
            '{CMD_FREE,  16'hFFFF,  16'hFFFF,  0, 1, '{16'd0,  ST_OK}},
            '{CMD_FREE,  16'd0,     16'd65528, 0, 1, '{16'd0,  ST_OK}},
            '{CMD_ALLOC, 16'd4080,  16'd0,     0, 0, '{16'd0,  ST_OK}},
            '{CMD_ALLOC, 16'd8,     16'd0,     0, 0, '{16'd0,  ST_OK}},
            '{CMD_ALLOC, 16'd5000,  16'd0,     0, 0, '{16'd0,  ST_OK}},
            '{CMD_ALLOC, 16'd100,   16'd0,     0, 0, '{16'd0,  ST_OK}},
            '{CMD_ALLOC, 16'd24,    16'd0,     0, 0, '{16'd0,  ST_OK}},
            '{CMD_FREE,  16'd0,     16'd0,     1, 1, '{16'd0,  ST_OK}},
            '{CMD_FREE,  16'd0,     16'd0,     1, 1, '{16'd0,  ST_OK}},
            '{CMD_ALLOC, 16'd1,     16'd0,     0, 0, '{16'd0,  ST_OK}},
            '{CMD_ALLOC, 16'h8000,  16'd0,     0, 0, '{16'd0,  ST_OK}},
            '{CMD_ALLOC, 16'h7FFF,  16'd0,     0, 0, '{16'd0,  ST_OK}},
            '{CMD_ALLOC, 16'd60000, 16'd0,     0, 0, '{16'd0,  ST_OK}},
            '{CMD_FREE,  16'hAAAA,  16'h5555,  0, 1, '{16'd0,  ST_OK}},
            '{CMD_FREE,  16'd0,     16'd0,     1, 1, '{16'd0,  ST_OK}},
            '{CMD_FREE,  16'd0,     16'd0,     1, 1, '{16'd0,  ST_OK}}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            w = rows[i];
            ba = w.take_live ? take_live(1'b1) : w.baddr;
            send_request(w.op, w.nbytes, ba, w.fixed, w.res);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            calm = (n >= 900 && n < 1200);
            r = $urandom_range(99);
            if (r < 55 || (r < 90 && live_q.size() == 0))
                send_request(CMD_ALLOC, pick_size(), 16'($urandom), 1'b0, none);
            else if (r < 90)
                send_request(CMD_FREE, 16'($urandom), take_live(1'b0), 1'b0, none);
            else
            begin
                // noise: mostly addresses the block must ignore
                ba = 16'($urandom);
                if (live_q.size() != 0 && $urandom_range(9) == 0)
                    ba = take_live(1'b0);
                else if (ba[2:0] == 3'd0 && ba >= 16 && ba < heap_end
                         && $urandom_range(9) != 0)
                    ba[0] = 1'b1;
                send_request(CMD_FREE, 16'($urandom), ba, 1'b0, none);
            end
        end
        calm = 1'b0;
        req_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // ---------------- result side ----------------
    always @(posedge clk or negedge rst_n)
    begin
        alloc_res_t want;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (pending_q.size() == 0)
                begin
                    $display("%0t: unexpected result addr %0d status %0d",
                             $time, result_addr, status);
                    errs++;
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (result_addr !== want.addr)
                    begin
                        $display("%0t: result_addr expected %0d actual %0d",
                                 $time, want.addr, result_addr);
                        errs++;
                    end
                    if (status !== want.st)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.st, status);
                        errs++;
                    end
                end
            end
            res_stall <= gap_now();
        end
    end

    // ---------------- watchdog and end of run ----------------
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        quiet_cycles = 0;
        wait (stim_done);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errs == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ffha_pkg.sv
rtl/ffha_datapath.sv
rtl/ffha_controller.sv
rtl/first_fit_heap_allocator.sv
tb/sv/tb.sv
